// File: design/bxcull_pkg.sv
// Shared constants, register indexes and status types for the building
// extrusion backface cull unit. No dependencies.
package bxcull_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int CENTER_W        = 22;
    localparam int TERM_W          = 36;
    localparam int DIGIT_W         = 4;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 36;

    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_TERM   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BUILDING_TERM = 2'd3;

    typedef struct packed {
        logic busy;
        logic fault;
    } shift_stat_t;

    typedef struct packed {
        logic busy;
        logic backface;
    } cross_stat_t;

endpackage

// File: design/bxcull_if.sv
// Valid/ready channel interfaces for vertex words and result words.
// Depends on bxcull_pkg for the default coordinate width.
interface bxcull_vertex_if import bxcull_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic                          ring_start;
    logic                          inner_ring;

    modport source (output valid, vertex_x, vertex_y, ring_start, inner_ring, input ready);
    modport sink (input valid, vertex_x, vertex_y, ring_start, inner_ring, output ready);
endinterface

interface bxcull_result_if import bxcull_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] roof_x;
    logic signed [COORD_WIDTH-1:0] roof_y;
    logic                          draw_side;
    logic signed [COORD_WIDTH-1:0] side_base_x;
    logic signed [COORD_WIDTH-1:0] side_base_y;
    logic signed [COORD_WIDTH-1:0] side_roof_x;
    logic signed [COORD_WIDTH-1:0] side_roof_y;
    logic                          shift_fault;

    modport source (output valid, roof_x, roof_y, draw_side, side_base_x, side_base_y,
                    side_roof_x, side_roof_y, shift_fault, input ready);
    modport sink (input valid, roof_x, roof_y, draw_side, side_base_x, side_base_y,
                  side_roof_x, side_roof_y, shift_fault, output ready);
endinterface

// File: design/bxcull_shift.sv
// Perspective roof shift: digit-serial multiply of |offset| by building_term,
// then bit-serial restoring division by camera_term + offset, x axis then y.
// Depends on bxcull_pkg.
module bxcull_shift import bxcull_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_WIDTH-1:0] vertex_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_y,
    input  logic [CENTER_W-1:0]           center_x,
    input  logic [CENTER_W-1:0]           center_y,
    input  logic [TERM_W-1:0]             camera_term,
    input  logic [TERM_W-1:0]             building_term,
    output logic signed [COORD_WIDTH-1:0] roof_x,
    output logic signed [COORD_WIDTH-1:0] roof_y,
    output shift_stat_t                   stat
);

    localparam int CW    = COORD_WIDTH;
    localparam int OFF_W = ((CW > CENTER_W) ? CW : CENTER_W) + 2;
    localparam int MAG_W = OFF_W - 1;
    localparam int ND    = (MAG_W + DIGIT_W - 1) / DIGIT_W;
    localparam int MUL_W = ND * DIGIT_W;
    localparam int DV_W  = ((TERM_W > OFF_W) ? TERM_W : OFF_W) + 2;
    localparam int DQ_W  = DV_W - 1;
    localparam int REM_W = DQ_W + 1;
    localparam int TOP_W = TERM_W + MUL_W - CW;
    localparam int SUM_W = TERM_W + DIGIT_W;
    localparam int RS_W  = CW + 2;
    localparam int CNT_W = $clog2(CW);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_ROOF = 3'd5;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    logic [2:0]              state_reg, state_next;
    logic                    axis_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [CW-1:0]    vx_reg, vy_reg;
    logic                    neg_reg, zero_reg, fault_reg, fault_acc_reg, ovf_reg;
    logic [MUL_W-1:0]        mul_reg;
    logic [MUL_W-1:0]        lo_reg;
    logic [TERM_W-1:0]       phi_reg;
    logic [DQ_W-1:0]         div_reg;
    logic [DQ_W-1:0]         rem_reg;
    logic [CW-1:0]           q_reg;
    logic signed [CW-1:0]    roof_x_reg, roof_y_reg;

    logic signed [CW-1:0]    v_sel;
    logic [CENTER_W-1:0]     c_sel;
    logic signed [OFF_W-1:0] offset;
    logic [OFF_W-1:0]        off_abs;
    logic signed [DV_W-1:0]  divisor;
    logic                    div_pos;
    logic [SUM_W-1:0]        mul_sum;
    logic [TOP_W-1:0]        top;
    logic [REM_W-1:0]        rem_sh;
    logic [REM_W-1:0]        rem_diff;
    logic                    rem_ge;
    logic signed [RS_W-1:0]  q_ext;
    logic signed [RS_W-1:0]  roof_sum;
    logic signed [CW-1:0]    roof_val;

    assign v_sel   = axis_reg ? vy_reg : vx_reg;
    assign c_sel   = axis_reg ? center_y : center_x;
    assign offset  = OFF_W'(v_sel) - $signed({{(OFF_W-CENTER_W){1'b0}}, c_sel});
    assign off_abs = offset[OFF_W-1] ? OFF_W'(-offset) : OFF_W'(offset);
    assign divisor = $signed({{(DV_W-TERM_W){1'b0}}, camera_term}) + DV_W'(offset);
    assign div_pos = !divisor[DV_W-1] && (divisor != '0);

    assign mul_sum = SUM_W'(phi_reg)
                   + SUM_W'(building_term) * SUM_W'(mul_reg[DIGIT_W-1:0]);

    assign top      = {phi_reg, lo_reg[MUL_W-1:CW]};
    assign rem_sh   = {rem_reg, lo_reg[CW-1]};
    assign rem_ge   = rem_sh >= REM_W'(div_reg);
    assign rem_diff = rem_sh - REM_W'(div_reg);

    assign q_ext    = $signed({2'b00, q_reg});
    assign roof_sum = RS_W'(v_sel) + (neg_reg ? -q_ext : q_ext);

    always_comb
    begin
        priority if (fault_reg && zero_reg)
        begin
            roof_val = v_sel;
        end
        else if (fault_reg || ovf_reg)
        begin
            roof_val = neg_reg ? C_MIN : C_MAX;
        end
        else if (roof_sum > RS_W'(C_MAX))
        begin
            roof_val = C_MAX;
        end
        else if (roof_sum < RS_W'(C_MIN))
        begin
            roof_val = C_MIN;
        end
        else
        begin
            roof_val = roof_sum[CW-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (cnt_reg == CNT_W'(ND - 1))
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(CW - 1))
                begin
                    state_next = S_ROOF;
                end
            end
            S_ROOF:
            begin
                state_next = axis_reg ? S_IDLE : S_PREP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            fault_acc_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        axis_reg      <= 1'b0;
                        fault_acc_reg <= 1'b0;
                    end
                end
                S_PREP:
                begin
                    cnt_reg <= '0;
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_CHK:
                begin
                    cnt_reg <= '0;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_ROOF:
                begin
                    axis_reg      <= 1'b1;
                    fault_acc_reg <= fault_acc_reg | fault_reg;
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    vx_reg <= vertex_x;
                    vy_reg <= vertex_y;
                end
            end
            S_PREP:
            begin
                neg_reg   <= offset[OFF_W-1];
                zero_reg  <= (offset == '0);
                fault_reg <= !div_pos;
                div_reg   <= divisor[DQ_W-1:0];
                mul_reg   <= MUL_W'(off_abs[MAG_W-1:0]);
                phi_reg   <= '0;
            end
            S_MUL:
            begin
                phi_reg <= mul_sum[SUM_W-1:DIGIT_W];
                lo_reg  <= {mul_sum[DIGIT_W-1:0], lo_reg[MUL_W-1:DIGIT_W]};
                mul_reg <= mul_reg >> DIGIT_W;
            end
            S_CHK:
            begin
                ovf_reg <= top >= TOP_W'(div_reg);
                rem_reg <= top[DQ_W-1:0];
            end
            S_DIV:
            begin
                rem_reg <= rem_ge ? rem_diff[DQ_W-1:0] : rem_sh[DQ_W-1:0];
                q_reg   <= {q_reg[CW-2:0], rem_ge};
                lo_reg  <= lo_reg << 1;
            end
            S_ROOF:
            begin
                if (axis_reg)
                begin
                    roof_y_reg <= roof_val;
                end
                else
                begin
                    roof_x_reg <= roof_val;
                end
            end
            default:
            begin
                q_reg <= '0;
            end
        endcase
    end

    assign roof_x     = roof_x_reg;
    assign roof_y     = roof_y_reg;
    assign stat.busy  = (state_reg != S_IDLE);
    assign stat.fault = fault_acc_reg;

endmodule

// File: design/bxcull_cross.sv
// Side-quad orientation: sign of a two-term cross product, formed digit-serially
// with both products folded into one narrow shifting accumulator.
// Depends on bxcull_pkg.
module bxcull_cross import bxcull_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_WIDTH-1:0] base_x,
    input  logic signed [COORD_WIDTH-1:0] base_y,
    input  logic signed [COORD_WIDTH-1:0] prev_base_x,
    input  logic signed [COORD_WIDTH-1:0] prev_base_y,
    input  logic signed [COORD_WIDTH-1:0] prev_roof_x,
    input  logic signed [COORD_WIDTH-1:0] prev_roof_y,
    output cross_stat_t                   stat
);

    localparam int CW    = COORD_WIDTH;
    localparam int D_W   = CW + 1;
    localparam int M_W   = D_W + 1;
    localparam int NDC   = (D_W + DIGIT_W - 1) / DIGIT_W;
    localparam int MG_W  = NDC * DIGIT_W;
    localparam int ACC_W = CW + 8;
    localparam int CNT_W = $clog2(NDC);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_PREP = 2'd1;
    localparam logic [1:0] C_RUN  = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     backface_reg;
    logic signed [D_W-1:0]    da_reg, db_reg, dc_reg, dd_reg;
    logic [MG_W-1:0]          ma_reg, mc_reg;
    logic signed [M_W-1:0]    bs_reg, ds_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic [D_W-1:0]           abs_a, abs_c;
    logic signed [DIGIT_W:0]  dig_a, dig_c;
    logic signed [ACC_W-1:0]  sum;

    assign abs_a = da_reg[D_W-1] ? D_W'(-da_reg) : D_W'(da_reg);
    assign abs_c = dc_reg[D_W-1] ? D_W'(-dc_reg) : D_W'(dc_reg);
    assign dig_a = $signed({1'b0, ma_reg[DIGIT_W-1:0]});
    assign dig_c = $signed({1'b0, mc_reg[DIGIT_W-1:0]});
    assign sum   = acc_reg + ACC_W'(dig_a) * ACC_W'(bs_reg)
                 - ACC_W'(dig_c) * ACC_W'(ds_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    state_next = C_PREP;
                end
            end
            C_PREP:
            begin
                state_next = C_RUN;
            end
            C_RUN:
            begin
                if (cnt_reg == CNT_W'(NDC - 1))
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= C_IDLE;
            cnt_reg      <= '0;
            backface_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == C_PREP)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == C_RUN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NDC - 1))
                begin
                    backface_reg <= !sum[ACC_W-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    da_reg <= D_W'(base_x) - D_W'(prev_base_x);
                    db_reg <= D_W'(prev_roof_y) - D_W'(prev_base_y);
                    dc_reg <= D_W'(base_y) - D_W'(prev_base_y);
                    dd_reg <= D_W'(prev_roof_x) - D_W'(prev_base_x);
                end
            end
            C_PREP:
            begin
                ma_reg  <= MG_W'(abs_a);
                mc_reg  <= MG_W'(abs_c);
                bs_reg  <= da_reg[D_W-1] ? -M_W'(db_reg) : M_W'(db_reg);
                ds_reg  <= dc_reg[D_W-1] ? -M_W'(dd_reg) : M_W'(dd_reg);
                acc_reg <= '0;
            end
            C_RUN:
            begin
                acc_reg <= sum >>> DIGIT_W;
                ma_reg  <= ma_reg >> DIGIT_W;
                mc_reg  <= mc_reg >> DIGIT_W;
            end
            default:
            begin
                acc_reg <= '0;
            end
        endcase
    end

    assign stat.busy     = (state_reg != C_IDLE);
    assign stat.backface = backface_reg;

endmodule

// File: design/building_extrusion_backface_cull_unit.sv
// After vertex accept, the shared multiply/divide datapath runs prep, multiply,
// check, divide and roof steps for x then y, one quotient bit per cycle per axis.
// The result is registered when shift and cross units are idle and the output is
// free; vertex ready stays low until then, so only one vertex is in flight.
// Reset (rst_n, asynchronous): clears config registers, previous vertex state and
// control; the block is ready for a vertex as soon as reset is released.
module building_extrusion_backface_cull_unit import bxcull_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    bxcull_vertex_if.sink          vertex,
    bxcull_result_if.source        result,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = COORD_WIDTH;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                 state_reg, state_next;
    logic [CENTER_W-1:0]  center_x_reg, center_y_reg;
    logic [TERM_W-1:0]    camera_term_reg, building_term_reg;
    logic signed [CW-1:0] base_x_reg, base_y_reg;
    logic                 tested_reg, inner_reg;
    logic signed [CW-1:0] prev_base_x_reg, prev_base_y_reg;
    logic signed [CW-1:0] prev_roof_x_reg, prev_roof_y_reg;
    logic                 have_prev_reg;
    logic                 out_valid_reg, out_valid_next;
    logic signed [CW-1:0] out_roof_x_reg, out_roof_y_reg;
    logic signed [CW-1:0] out_base_x_reg, out_base_y_reg;
    logic signed [CW-1:0] out_side_x_reg, out_side_y_reg;
    logic                 out_draw_reg, out_fault_reg;

    logic                 accept;
    logic                 finish;
    logic signed [CW-1:0] roof_x, roof_y;
    shift_stat_t          sh_stat;
    cross_stat_t          cr_stat;

    assign vertex.ready = (state_reg == ST_IDLE);
    assign accept       = vertex.valid && vertex.ready;
    assign finish       = (state_reg == ST_RUN) && !sh_stat.busy && !cr_stat.busy
                          && (!out_valid_reg || result.ready);

    bxcull_shift #(.COORD_WIDTH(CW)) u_shift (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (accept),
        .vertex_x      (vertex.vertex_x),
        .vertex_y      (vertex.vertex_y),
        .center_x      (center_x_reg),
        .center_y      (center_y_reg),
        .camera_term   (camera_term_reg),
        .building_term (building_term_reg),
        .roof_x        (roof_x),
        .roof_y        (roof_y),
        .stat          (sh_stat)
    );

    bxcull_cross #(.COORD_WIDTH(CW)) u_cross (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .base_x      (vertex.vertex_x),
        .base_y      (vertex.vertex_y),
        .prev_base_x (prev_base_x_reg),
        .prev_base_y (prev_base_y_reg),
        .prev_roof_x (prev_roof_x_reg),
        .prev_roof_y (prev_roof_y_reg),
        .stat        (cr_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            have_prev_reg     <= 1'b0;
            prev_base_x_reg   <= '0;
            prev_base_y_reg   <= '0;
            prev_roof_x_reg   <= '0;
            prev_roof_y_reg   <= '0;
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            camera_term_reg   <= '0;
            building_term_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (finish)
            begin
                have_prev_reg   <= 1'b1;
                prev_base_x_reg <= base_x_reg;
                prev_base_y_reg <= base_y_reg;
                prev_roof_x_reg <= roof_x;
                prev_roof_y_reg <= roof_y;
            end
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_CENTER_X:      center_x_reg      <= cfg_data[CENTER_W-1:0];
                    REG_CENTER_Y:      center_y_reg      <= cfg_data[CENTER_W-1:0];
                    REG_CAMERA_TERM:   camera_term_reg   <= cfg_data[TERM_W-1:0];
                    REG_BUILDING_TERM: building_term_reg <= cfg_data[TERM_W-1:0];
                    default:           center_x_reg      <= center_x_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_x_reg <= vertex.vertex_x;
            base_y_reg <= vertex.vertex_y;
            tested_reg <= have_prev_reg && !vertex.ring_start;
            inner_reg  <= vertex.inner_ring;
        end
        if (finish)
        begin
            out_roof_x_reg <= roof_x;
            out_roof_y_reg <= roof_y;
            out_fault_reg  <= sh_stat.fault;
            out_draw_reg   <= tested_reg && (inner_reg ? cr_stat.backface : !cr_stat.backface);
            out_base_x_reg <= tested_reg ? prev_base_x_reg : '0;
            out_base_y_reg <= tested_reg ? prev_base_y_reg : '0;
            out_side_x_reg <= tested_reg ? prev_roof_x_reg : '0;
            out_side_y_reg <= tested_reg ? prev_roof_y_reg : '0;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.roof_x      = out_roof_x_reg;
    assign result.roof_y      = out_roof_y_reg;
    assign result.draw_side   = out_draw_reg;
    assign result.side_base_x = out_base_x_reg;
    assign result.side_base_y = out_base_y_reg;
    assign result.side_roof_x = out_side_x_reg;
    assign result.side_roof_y = out_side_y_reg;
    assign result.shift_fault = out_fault_reg;

endmodule

// File: design/bxcull_checker.sv
// Port-level checks for the building extrusion backface cull unit, bound to
// the top level. Depends on bxcull_pkg and the top level's ports.
module bxcull_checker import bxcull_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [COORD_WIDTH-1:0] roof_x,
    input logic [COORD_WIDTH-1:0] roof_y,
    input logic                   draw_side,
    input logic                   shift_fault
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // one vertex word at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("vertex accepted on back-to-back cycles");

    // result is never raised in the cycle after a vertex accept
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !$rose(out_valid))
        else $error("result word raised too early after vertex accept");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(roof_x) && $stable(roof_y)
                                    && $stable(draw_side) && $stable(shift_fault))
        else $error("result word changed while stalled");

endmodule

bind building_extrusion_backface_cull_unit bxcull_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_bxcull_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (vertex.valid),
    .in_ready    (vertex.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .roof_x      (result.roof_x),
    .roof_y      (result.roof_y),
    .draw_side   (result.draw_side),
    .shift_fault (result.shift_fault)
);

// File: sim/tb_building_extrusion_backface_cull_unit.sv
`timescale 1ns / 100ps
// Testbench for building_extrusion_backface_cull_unit: directed vertex table plus random
// outline rings, results checked against typed rows or an in-bench roof/cull predictor.
// Depends on bxcull_pkg and the bxcull channel interfaces.
module tb_building_extrusion_backface_cull_unit;
    import bxcull_pkg::*;

    localparam int CW              = COORD_WIDTH_DEF;
    localparam int PX              = 256;
    localparam int RESET_ROWS      = 4;
    localparam int RAND_PHASES     = 7;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int HOLD_AFTER      = 300;
    localparam int HOLD_CYCLES     = 1500;
    localparam int STEADY_PHASE    = 2;

    typedef logic signed [CW-1:0] coord_t;

    localparam longint COORD_MAX_L = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint COORD_MIN_L = -COORD_MAX_L - 1;
    localparam longint SAT_SHIFT   = 64'sh4000_0000_0000_0000;
    localparam logic [127:0] QUOT_CAP = 128'd1 << 62;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   ring_start;
        logic   inner_ring;
    } vertex_word_t;

    typedef struct {
        coord_t roof_x;
        coord_t roof_y;
        logic   draw_side;
        coord_t side_base_x;
        coord_t side_base_y;
        coord_t side_roof_x;
        coord_t side_roof_y;
        logic   shift_fault;
    } result_word_t;

    typedef struct {
        vertex_word_t v;
        bit           typed;
        result_word_t want;
    } vector_row_t;

    logic clk;
    logic rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bxcull_vertex_if #(.COORD_WIDTH(CW)) vertex_ch ();
    bxcull_result_if #(.COORD_WIDTH(CW)) result_ch ();

    building_extrusion_backface_cull_unit #(.COORD_WIDTH(CW)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vertex    (vertex_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [CENTER_W-1:0] ctr_x, ctr_y;
    logic [TERM_W-1:0]   cam_term, bld_term;
    coord_t              prev_bx, prev_by, prev_rx, prev_ry;
    bit                  have_prev;

    result_word_t expected_words[$];
    vector_row_t  directed_rows[$];
    int           errors;
    int           results_seen;
    int           burst_left;
    bit           steady;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #15_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic coord_t roof_axis(input coord_t v, input logic [CENTER_W-1:0] ctr,
                                         output bit hit);
        longint       off, dv, sh, sum;
        logic [63:0]  off_mag;
        logic [127:0] prod, quo;
        hit = 1'b0;
        off = longint'(v) - longint'(ctr);
        dv  = longint'(cam_term) + off;
        if (dv <= 0)
        begin
            hit = 1'b1;
            if (off > 0)
                sh = SAT_SHIFT;
            else if (off < 0)
                sh = -SAT_SHIFT;
            else
                sh = 0;
        end
        else
        begin
            off_mag = (off < 0) ? -off : off;
            prod    = {64'd0, off_mag} * {92'd0, bld_term};
            quo     = prod / {64'd0, dv};
            if (quo > QUOT_CAP)
                quo = QUOT_CAP;
            sh = (off < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        end
        sum = longint'(v) + sh;
        if (sum > COORD_MAX_L)
            sum = COORD_MAX_L;
        else if (sum < COORD_MIN_L)
            sum = COORD_MIN_L;
        return sum[CW-1:0];
    endfunction

    function automatic result_word_t extrude_vertex(input vertex_word_t w);
        result_word_t r;
        coord_t       bx, by;
        bit           fx, fy, tested, backface;
        longint       cross_val;
        bx = w.x;
        by = w.y;
        r.roof_x = roof_axis(bx, ctr_x, fx);
        r.roof_y = roof_axis(by, ctr_y, fy);
        tested = have_prev && !w.ring_start;
        r.draw_side = 1'b0;
        if (tested)
        begin
            cross_val = (longint'(bx) - longint'(prev_bx)) * (longint'(prev_ry) - longint'(prev_by))
                      - (longint'(by) - longint'(prev_by)) * (longint'(prev_rx) - longint'(prev_bx));
            backface = cross_val >= 0;
            r.draw_side = w.inner_ring ? backface : !backface;
        end
        r.side_base_x = tested ? prev_bx : '0;
        r.side_base_y = tested ? prev_by : '0;
        r.side_roof_x = tested ? prev_rx : '0;
        r.side_roof_y = tested ? prev_ry : '0;
        r.shift_fault = fx | fy;
        prev_bx   = bx;
        prev_by   = by;
        prev_rx   = r.roof_x;
        prev_ry   = r.roof_y;
        have_prev = 1'b1;
        return r;
    endfunction

    function automatic vertex_word_t vw(input longint x, input longint y, input bit s,
                                        input bit i);
        vertex_word_t w;
        w.x = x[CW-1:0];
        w.y = y[CW-1:0];
        w.ring_start = s;
        w.inner_ring = i;
        return w;
    endfunction

    function automatic result_word_t rw(input longint rx, input longint ry, input bit d,
                                        input longint bx, input longint by, input longint sx,
                                        input longint sy, input bit f);
        result_word_t r;
        r.roof_x = rx[CW-1:0];
        r.roof_y = ry[CW-1:0];
        r.draw_side = d;
        r.side_base_x = bx[CW-1:0];
        r.side_base_y = by[CW-1:0];
        r.side_roof_x = sx[CW-1:0];
        r.side_roof_y = sy[CW-1:0];
        r.shift_fault = f;
        return r;
    endfunction

    function automatic void add_row(input vertex_word_t v, input bit typed,
                                    input result_word_t want);
        vector_row_t row;
        row.v = v;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand36();
        logic [63:0] tmp;
        tmp = {$urandom, $urandom};
        return tmp[CFG_DATA_W-1:0];
    endfunction

    function automatic coord_t rand_coord(input logic [CENTER_W-1:0] ctr);
        int          kind;
        longint      c;
        logic [31:0] raw;
        kind = $urandom_range(0, 9);
        if (kind <= 6)
            c = longint'(ctr) + longint'($urandom_range(0, 32'h0020_0000)) - 64'sd1048576;
        else if (kind <= 8)
        begin
            raw = $urandom;
            c = longint'(raw);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: c = COORD_MAX_L;
                1: c = COORD_MIN_L;
                2: c = 0;
                default: c = -1;
            endcase
        end
        return c[CW-1:0];
    endfunction

    task automatic note_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [CW-1:0] got,
                               input logic [CW-1:0] want);
        if (got !== want)
            note_mismatch($sformatf("word %0d %s got %h expected %h",
                                    results_seen, name, got, want));
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_CENTER_X:      ctr_x = data[CENTER_W-1:0];
            REG_CENTER_Y:      ctr_y = data[CENTER_W-1:0];
            REG_CAMERA_TERM:   cam_term = data[TERM_W-1:0];
            REG_BUILDING_TERM: bld_term = data[TERM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_cfg(input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy,
                               input logic [CFG_DATA_W-1:0] ct,
                               input logic [CFG_DATA_W-1:0] bt);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CAMERA_TERM, ct);
        write_reg(REG_BUILDING_TERM, bt);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        vertex_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_vertex(input vertex_word_t w, input bit typed, input result_word_t want);
        result_word_t pred;
        int           gap;
        if (burst_left == 0)
        begin
            gap = 0;
            if (!steady)
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 120) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                @(negedge clk);
                vertex_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge clk);
        vertex_ch.valid      <= 1'b1;
        vertex_ch.vertex_x   <= w.x;
        vertex_ch.vertex_y   <= w.y;
        vertex_ch.ring_start <= w.ring_start;
        vertex_ch.inner_ring <= w.inner_ring;
        do
            @(posedge clk);
        while (!vertex_ch.ready);
        pred = extrude_vertex(w);
        expected_words.push_back(typed ? want : pred);
    endtask

    // receiver: pattern of stalls, with one long hold-off
    initial
    begin
        int rx_cycle;
        int mode;
        bit held;
        rx_cycle = 0;
        mode = 0;
        held = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_cycle += HOLD_CYCLES;
            end
            if (rx_cycle % 512 == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= ($urandom_range(0, 9) < 7);
                default: result_ch.ready <= (rx_cycle % 8) >= 3;
            endcase
        end
    end

    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_words.size() == 0)
                note_mismatch($sformatf("word %0d arrived with none expected", results_seen));
            else
            begin
                want = expected_words.pop_front();
                check_field("roof_x", result_ch.roof_x, want.roof_x);
                check_field("roof_y", result_ch.roof_y, want.roof_y);
                check_field("draw_side", CW'(result_ch.draw_side), CW'(want.draw_side));
                check_field("side_base_x", result_ch.side_base_x, want.side_base_x);
                check_field("side_base_y", result_ch.side_base_y, want.side_base_y);
                check_field("side_roof_x", result_ch.side_roof_x, want.side_roof_x);
                check_field("side_roof_y", result_ch.side_roof_y, want.side_roof_y);
                check_field("shift_fault", CW'(result_ch.shift_fault), CW'(want.shift_fault));
            end
            results_seen++;
        end
    end

    initial
    begin
        result_word_t none;
        vertex_word_t w;
        logic [CFG_DATA_W-1:0] cx, cy, ct, bt;
        int left, ring_len, k;
        bit ring_inner;

        errors = 0;
        results_seen = 0;
        burst_left = 0;
        steady = 1'b0;
        ctr_x = '0;
        ctr_y = '0;
        cam_term = '0;
        bld_term = '0;
        prev_bx = '0;
        prev_by = '0;
        prev_rx = '0;
        prev_ry = '0;
        have_prev = 1'b0;
        none = rw(0, 0, 0, 0, 0, 0, 0, 0);

        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        vertex_ch.valid = 1'b0;
        vertex_ch.vertex_x = '0;
        vertex_ch.vertex_y = '0;
        vertex_ch.ring_start = 1'b0;
        vertex_ch.inner_ring = 1'b0;

        // reset config: zero centre and zero terms
        add_row(vw(0, 0, 1, 0), 1, rw(0, 0, 0, 0, 0, 0, 0, 1));
        add_row(vw(COORD_MAX_L, COORD_MAX_L, 0, 0), 1,
                rw(COORD_MAX_L, COORD_MAX_L, 0, 0, 0, 0, 0, 0));
        add_row(vw(COORD_MIN_L, COORD_MIN_L, 0, 1), 1,
                rw(COORD_MIN_L, COORD_MIN_L, 1, COORD_MAX_L, COORD_MAX_L,
                   COORD_MAX_L, COORD_MAX_L, 1));
        add_row(vw(COORD_MIN_L, COORD_MAX_L, 1, 0), 1,
                rw(COORD_MIN_L, COORD_MAX_L, 0, 0, 0, 0, 0, 1));
        // typical viewport: outer square both windings, inner ring, centre, extremes
        add_row(vw(100 * PX, 100 * PX, 1, 0), 0, none);
        add_row(vw(300 * PX, 100 * PX, 0, 0), 0, none);
        add_row(vw(300 * PX, 300 * PX, 0, 0), 0, none);
        add_row(vw(100 * PX, 300 * PX, 0, 0), 0, none);
        add_row(vw(100 * PX, 100 * PX, 1, 0), 0, none);
        add_row(vw(100 * PX, 300 * PX, 0, 0), 0, none);
        add_row(vw(300 * PX, 300 * PX, 0, 0), 0, none);
        add_row(vw(300 * PX, 100 * PX, 0, 0), 0, none);
        add_row(vw(150 * PX, 150 * PX, 1, 1), 0, none);
        add_row(vw(250 * PX, 150 * PX, 0, 1), 0, none);
        add_row(vw(250 * PX, 250 * PX, 0, 1), 0, none);
        add_row(vw(640 * PX, 360 * PX, 0, 0), 0, none);
        add_row(vw(COORD_MAX_L, COORD_MAX_L, 0, 0), 0, none);
        add_row(vw(COORD_MIN_L, COORD_MIN_L, 0, 0), 0, none);
        add_row(vw(COORD_MAX_L, COORD_MIN_L, 0, 1), 0, none);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < directed_rows.size(); i++)
        begin
            if (i == RESET_ROWS)
            begin
                drain();
                program_cfg(640 * PX, 360 * PX, 36'h1_0000_0000, 36'h0_1000_0000);
            end
            send_vertex(directed_rows[i].v, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain();
            steady = (ph == STEADY_PHASE);
            case (ph)
                0:
                begin
                    cx = '1;
                    cy = '1;
                    ct = '1;
                    bt = '1;
                end
                1:
                begin
                    cx = '0;
                    cy = '0;
                    ct = '0;
                    bt = '0;
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0, 1:
                        begin
                            cx = {4'd0, $urandom_range(0, 32'h0020_0000)};
                            cy = {4'd0, $urandom_range(0, 32'h0020_0000)};
                            ct = 36'h1000_0000 * $urandom_range(1, 127);
                            bt = {4'd0, $urandom_range(0, 32'h3FFF_FFFF)};
                        end
                        2:
                        begin
                            cx = {4'd0, $urandom_range(0, 32'h003F_FFFF)};
                            cy = {4'd0, $urandom_range(0, 32'h003F_FFFF)};
                            ct = {4'd0, $urandom_range(0, 32'h0040_0000)};
                            bt = rand36();
                        end
                        default:
                        begin
                            cx = rand36();
                            cy = rand36();
                            ct = rand36();
                            bt = rand36();
                        end
                    endcase
                end
            endcase
            program_cfg(cx, cy, ct, bt);

            left = ITEMS_PER_PHASE;
            while (left > 0)
            begin
                ring_len = $urandom_range(2, 10);
                ring_inner = ($urandom_range(0, 3) == 0);
                for (k = 0; k < ring_len && left > 0; k++)
                begin
                    w.x = rand_coord(ctr_x);
                    w.y = rand_coord(ctr_y);
                    w.ring_start = (k == 0);
                    w.inner_ring = ring_inner;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        w.ring_start = 1'($urandom_range(0, 1));
                        w.inner_ring = 1'($urandom_range(0, 1));
                    end
                    send_vertex(w, 0, none);
                    left--;
                end
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
